[rtl/core/calendar_to_gps_seconds_assert.svh]
// ----------------------------------------------------------------------------
// calendar_to_gps_seconds_assert.svh
// Assertion macros shared by the date conversion RTL.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TO_GPS_SECONDS_ASSERT_SVH
`define CALENDAR_TO_GPS_SECONDS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define C2GPS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c2gps: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define C2GPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c2gps: next-cycle check failed");

`endif

[rtl/core/c2gps_pkg.sv]
// ----------------------------------------------------------------------------
// c2gps_pkg
// Constants and the month table for the calendar to GPS seconds converter.
// ----------------------------------------------------------------------------
package c2gps_pkg;

   localparam int YEAR_W   = 7;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int GPS_W    = 32;

   // day count stays below 2^16 for every year code, time of day below 2^17
   localparam int DAYS_W = 16;
   localparam int TOD_W  = 17;

   localparam logic [DAYS_W-1:0] DAYS_1980_TO_2000 = 16'd7305;
   localparam logic [DAYS_W-1:0] DAYS_PER_YEAR     = 16'd365;
   // one for the 1-based day, five for epoch on Jan 6
   localparam logic [DAYS_W-1:0] DAY_OFFSET        = 16'd6;
   localparam logic [YEAR_W-1:0] YEAR_2100         = 7'd100;
   localparam logic [MONTH_W-1:0] MONTH_FEB        = 4'd2;

   localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [GPS_W-1:0] SECS_PER_DAY  = 32'd86400;

   // Days before the first of the month; codes outside 1..12 add nothing.
   function automatic logic [8:0] month_start_days(input logic [MONTH_W-1:0] mon);
      logic [8:0] d;
      case (mon)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

[rtl/core/calendar_to_gps_seconds.sv]
// ----------------------------------------------------------------------------
// calendar_to_gps_seconds
// Converts a binary calendar time (years 2000..2127) to seconds since the
// GPS epoch, 1980-01-06 00:00:00, modulo 2^32.
// ----------------------------------------------------------------------------
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+-----------------
//  request | req_year_in_century .. req_second_value           | req_valid/ready
//  result  | rsp_gps_seconds                                   | rsp_valid/ready
//
//  Three register stages: input, day count / time of day, result.
//  One request per cycle while rsp_ready is held high.
//  The result multiply (days x 86400) sets the longest path.
//  Each stage fills while the one after it holds, so bubbles close up under
//  rsp_ready stalls; req_ready drops only with all three stages full.
//  Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "calendar_to_gps_seconds_assert.svh"

module calendar_to_gps_seconds (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [c2gps_pkg::YEAR_W-1:0]       req_year_in_century,
   input  logic [c2gps_pkg::MONTH_W-1:0]      req_month_number,
   input  logic [c2gps_pkg::DAY_W-1:0]        req_day_of_month,
   input  logic [c2gps_pkg::HOUR_W-1:0]       req_hour_value,
   input  logic [c2gps_pkg::MINUTE_W-1:0]     req_minute_value,
   input  logic [c2gps_pkg::SECOND_W-1:0]     req_second_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [c2gps_pkg::GPS_W-1:0]        rsp_gps_seconds
);

   // stage A: captured request
   logic                              a_valid_ff;
   logic [c2gps_pkg::YEAR_W-1:0]      a_year_ff;
   logic [c2gps_pkg::MONTH_W-1:0]     a_month_ff;
   logic [c2gps_pkg::DAY_W-1:0]       a_day_ff;
   logic [c2gps_pkg::HOUR_W-1:0]      a_hour_ff;
   logic [c2gps_pkg::MINUTE_W-1:0]    a_minute_ff;
   logic [c2gps_pkg::SECOND_W-1:0]    a_second_ff;

   // stage B: day count and time of day
   logic                              b_valid_ff;
   logic [c2gps_pkg::DAYS_W-1:0]      b_days_ff;
   logic [c2gps_pkg::DAYS_W-1:0]      b_days_in;
   logic [c2gps_pkg::TOD_W-1:0]       b_tod_ff;
   logic [c2gps_pkg::TOD_W-1:0]       b_tod_in;

   // stage C: result
   logic                              c_valid_ff;
   logic [c2gps_pkg::GPS_W-1:0]       c_gps_ff;
   logic [c2gps_pkg::GPS_W-1:0]       c_gps_in;

   logic en_c;
   logic en_b;
   logic en_a;

   logic [c2gps_pkg::DAYS_W-1:0] leaps;
   logic                         is_leap;
   logic                         leap_day;

   assign en_c = !c_valid_ff || rsp_ready;
   assign en_b = !b_valid_ff || en_c;
   assign en_a = !a_valid_ff || en_b;

   assign req_ready       = en_a;
   assign rsp_valid       = c_valid_ff;
   assign rsp_gps_seconds = c_gps_ff;

   // leap years from 2000 up to the year before; 2100 is not leap
   always_comb begin
      leaps = c2gps_pkg::DAYS_W'((c2gps_pkg::YEAR_W+1)'(a_year_ff) + 8'd3) >> 2;
      if (a_year_ff > c2gps_pkg::YEAR_2100) begin
         leaps = leaps - 16'd1;
      end
      is_leap  = (a_year_ff[1:0] == 2'd0) && (a_year_ff != c2gps_pkg::YEAR_2100);
      leap_day = is_leap && (a_month_ff > c2gps_pkg::MONTH_FEB);
   end

   assign b_days_in = c2gps_pkg::DAYS_1980_TO_2000
                    + c2gps_pkg::DAYS_PER_YEAR * c2gps_pkg::DAYS_W'(a_year_ff)
                    + leaps
                    + c2gps_pkg::DAYS_W'(c2gps_pkg::month_start_days(a_month_ff))
                    + c2gps_pkg::DAYS_W'(leap_day)
                    + c2gps_pkg::DAYS_W'(a_day_ff)
                    - c2gps_pkg::DAY_OFFSET;

   assign b_tod_in = c2gps_pkg::SECS_PER_HOUR * c2gps_pkg::TOD_W'(a_hour_ff)
                   + c2gps_pkg::SECS_PER_MIN * c2gps_pkg::TOD_W'(a_minute_ff)
                   + c2gps_pkg::TOD_W'(a_second_ff);

   assign c_gps_in = c2gps_pkg::GPS_W'(b_days_ff) * c2gps_pkg::SECS_PER_DAY
                   + c2gps_pkg::GPS_W'(b_tod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= req_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (en_c) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req_valid) begin
         a_year_ff   <= req_year_in_century;
         a_month_ff  <= req_month_number;
         a_day_ff    <= req_day_of_month;
         a_hour_ff   <= req_hour_value;
         a_minute_ff <= req_minute_value;
         a_second_ff <= req_second_value;
      end
      if (en_b && a_valid_ff) begin
         b_days_ff <= b_days_in;
         b_tod_ff  <= b_tod_in;
      end
      if (en_c && b_valid_ff) begin
         c_gps_ff <= c_gps_in;
      end
   end

   // backpressure only when every stage holds a request
   `C2GPS_ASSERT_IMPL(a_full_stall, !req_ready, a_valid_ff && b_valid_ff && c_valid_ff)
   // a held middle stage keeps its operands
   `C2GPS_ASSERT_NEXT(b_hold, b_valid_ff && !en_c, b_valid_ff && $stable(b_days_ff) && $stable(b_tod_ff))
   // a request in the middle stage reaches the output as soon as it frees up
   `C2GPS_ASSERT_NEXT(b_to_c, b_valid_ff && en_c, c_valid_ff)
   // result leaves only through a handshake
   `C2GPS_ASSERT_IMPL(c_drop, $fell(c_valid_ff), $past(rsp_ready))

endmodule

[sim/calendar_to_gps_seconds_tb.sv]
// ----------------------------------------------------------------------------
// calendar_to_gps_seconds_tb
// Drives calendar times into the converter and checks every GPS second count
// against a local date arithmetic predictor. There is a directed pass over
// the field extremes, leap and century corners and the out-of-range codes.
// After it comes a random mix of plausible dates and raw field noise. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module calendar_to_gps_seconds_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_RANDOM   = 1850;
   localparam int unsigned HOLD_AT      = 700;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam logic [c2gps_pkg::MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [c2gps_pkg::YEAR_W-1:0]   year;
      logic [c2gps_pkg::MONTH_W-1:0]  month;
      logic [c2gps_pkg::DAY_W-1:0]    day;
      logic [c2gps_pkg::HOUR_W-1:0]   hour;
      logic [c2gps_pkg::MINUTE_W-1:0] minute;
      logic [c2gps_pkg::SECOND_W-1:0] second;
   } date_req_type;

   localparam int REQ_BITS = $bits(date_req_type);

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [c2gps_pkg::YEAR_W-1:0]   req_year_in_century = '0;
   logic [c2gps_pkg::MONTH_W-1:0]  req_month_number = '0;
   logic [c2gps_pkg::DAY_W-1:0]    req_day_of_month = '0;
   logic [c2gps_pkg::HOUR_W-1:0]   req_hour_value = '0;
   logic [c2gps_pkg::MINUTE_W-1:0] req_minute_value = '0;
   logic [c2gps_pkg::SECOND_W-1:0] req_second_value = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [c2gps_pkg::GPS_W-1:0]    rsp_gps_seconds;

   date_req_type                pending_dates[$];
   logic [c2gps_pkg::GPS_W-1:0] expected_gps[$];
   date_req_type                offered_date;
   int unsigned      error_count = 0;
   int unsigned      accepted_count = 0;
   int unsigned      offered_count = 0;
   int unsigned      send_gap = 0;
   int unsigned      recv_gap = 0;
   int unsigned      results_seen = 0;
   bit               send_burst = 1'b0;
   bit               recv_burst = 1'b0;
   int unsigned      hold_left = 0;
   bit               hold_done = 1'b0;
   bit               long_hold = 1'b0;

   calendar_to_gps_seconds dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_year_in_century (req_year_in_century),
      .req_month_number    (req_month_number),
      .req_day_of_month    (req_day_of_month),
      .req_hour_value      (req_hour_value),
      .req_minute_value    (req_minute_value),
      .req_second_value    (req_second_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_gps_seconds     (rsp_gps_seconds)
   );

   always #4 clock = ~clock;

   function automatic int unsigned month_length(input int unsigned m);
      if (m == c2gps_pkg::MONTH_FEB) return 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   // Gregorian count from 1980-01-01; year codes past 99 run into 2100,
   // which is not a leap year.
   function automatic logic [c2gps_pkg::GPS_W-1:0] gps_seconds_of(input date_req_type d);
      logic [31:0] y;
      logic [31:0] leaps;
      logic [31:0] days;
      logic        leap_year;
      y         = 32'(d.year);
      leaps     = (y + 32'd3) / 32'd4;
      if (y > 32'(c2gps_pkg::YEAR_2100)) leaps = leaps - 32'd1;
      days      = 32'(c2gps_pkg::DAYS_1980_TO_2000) + 32'd365 * y + leaps;
      leap_year = (y[1:0] == 2'b00) && (y != 32'(c2gps_pkg::YEAR_2100));
      if (d.month >= 4'd1 && d.month <= MONTH_DEC) begin
         for (int unsigned m = 1; m < d.month; m++) days = days + month_length(m);
      end
      if (d.month > c2gps_pkg::MONTH_FEB && leap_year) days = days + 32'd1;
      days = days + 32'(d.day) - 32'd6;
      return days * 32'd86400 + 32'(d.hour) * 32'd3600 + 32'(d.minute) * 32'd60
             + 32'(d.second);
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic queue_date(input int y, input int mo, input int dd, input int h,
                             input int mi, input int s);
      date_req_type d;
      d.year   = c2gps_pkg::YEAR_W'(y);
      d.month  = c2gps_pkg::MONTH_W'(mo);
      d.day    = c2gps_pkg::DAY_W'(dd);
      d.hour   = c2gps_pkg::HOUR_W'(h);
      d.minute = c2gps_pkg::MINUTE_W'(mi);
      d.second = c2gps_pkg::SECOND_W'(s);
      pending_dates.push_back(d);
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_gps.push_back(gps_seconds_of(offered_date));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_dates.size() > 0) begin
               offered_date = pending_dates.pop_front();
               req_year_in_century <= offered_date.year;
               req_month_number    <= offered_date.month;
               req_day_of_month    <= offered_date.day;
               req_hour_value      <= offered_date.hour;
               req_minute_value    <= offered_date.minute;
               req_second_value    <= offered_date.second;
               req_valid           <= 1'b1;
               if (offered_count % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
               offered_count++;
               send_gap = send_burst ? 0 : $urandom_range(0, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- long receiver hold-off ----------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         long_hold <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         long_hold <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         long_hold <= (hold_left > 1);
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      logic [c2gps_pkg::GPS_W-1:0] want;
      bit                          ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_gps.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", rsp_gps_seconds));
            end else begin
               want = expected_gps.pop_front();
               if (rsp_gps_seconds !== want)
                  report_mismatch($sformatf("gps_seconds got %0d want %0d",
                                            rsp_gps_seconds, want));
            end
            if (results_seen % 50 == 0) recv_burst = ($urandom_range(0, 2) == 0);
            results_seen++;
            recv_gap = recv_burst ? 0 : $urandom_range(0, 7);
         end
         ready_next = 1'b1;
         if (recv_gap > 0) begin
            recv_gap--;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next && !long_hold;
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      date_req_type d;
      logic [63:0]  noise;
      // field extremes, leap handling, century rollover, odd month codes
      queue_date(0, 1, 1, 0, 0, 0);
      queue_date(0, 0, 0, 0, 0, 0);
      queue_date(99, 12, 31, 23, 59, 59);
      queue_date(127, 15, 31, 31, 63, 63);
      queue_date(0, 2, 29, 12, 30, 30);
      queue_date(0, 3, 1, 0, 0, 0);
      queue_date(1, 3, 1, 0, 0, 0);
      queue_date(4, 13, 5, 1, 2, 3);
      queue_date(5, 14, 5, 1, 2, 3);
      queue_date(96, 15, 1, 0, 0, 0);
      queue_date(100, 3, 1, 0, 0, 0);
      queue_date(100, 2, 28, 23, 59, 59);
      queue_date(101, 1, 1, 0, 0, 0);
      queue_date(104, 3, 1, 0, 0, 0);
      queue_date(116, 6, 15, 6, 28, 16);
      queue_date(118, 1, 1, 0, 0, 0);
      for (int m = 1; m <= 12; m++) queue_date(24, m, 10, 5, 6, 7);

      for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 4) != 0) begin
            d.year   = c2gps_pkg::YEAR_W'($urandom_range(0, 99));
            d.month  = c2gps_pkg::MONTH_W'($urandom_range(1, 12));
            d.day    = c2gps_pkg::DAY_W'($urandom_range(1, 31));
            d.hour   = c2gps_pkg::HOUR_W'($urandom_range(0, 23));
            d.minute = c2gps_pkg::MINUTE_W'($urandom_range(0, 59));
            d.second = c2gps_pkg::SECOND_W'($urandom_range(0, 59));
         end else begin
            noise = {$urandom(), $urandom()};
            d     = noise[REQ_BITS-1:0];
         end
         pending_dates.push_back(d);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() > 0 || req_valid || expected_gps.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_gps.size() == 0) begin
         $display("** calendar_to_gps_seconds: PASSED **");
      end else begin
         $display("** calendar_to_gps_seconds: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout: %0d results still expected", expected_gps.size());
      $display("** calendar_to_gps_seconds: FAILED **");
      $finish;
   end

endmodule
